// ----- rtl/core/eddy_cfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy channel feature extract: shared package
// Widths, command and status bundles, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package eddy_cfe_pkg;

   localparam int DEFAULT_CHANNELS         = 32;
   localparam int DEFAULT_ANGLE_ITERATIONS = 16;

   localparam int COUNT_W    = 8;
   localparam int CHAN_W     = 5;
   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 24;            // holds 255 summed samples
   localparam int DIV_STEPS  = ACC_W;         // one quotient bit per cycle
   localparam int SQRT_STEPS = 25;            // one root bit per cycle
   localparam int STEP_W     = 5;             // covers DIV_STEPS and SQRT_STEPS
   localparam int ZW         = 25;            // angle, degrees * 65536
   localparam int CW         = 35;            // CORDIC x and y
   localparam int AMP_W      = 17;
   localparam int PHASE_W    = 17;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [COUNT_W-1:0]   COUNT_RESET = 8'd20;
   localparam logic signed [ZW-1:0] Z_QUARTER   = 25'sd5898240;   // 90 degrees
   localparam logic [PHASE_W-1:0]   PHASE_LIMIT = 17'd36000;

   typedef struct packed {
      logic              accept;
      logic              div_step;
      logic              average;
      logic              delta;
      logic              square_a;
      logic              square_b;
      logic              iterate;
      logic              phase;
      logic              load_out;
      logic [STEP_W-1:0] step;
   } cfe_cmd_type;

   typedef struct packed {
      logic group_done;
      logic is_cal;
      logic out_free;
   } cfe_status_type;

   // atan(2^-i) in degrees * 65536, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_angle(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] a;
      unique case (idx)
         5'd0:    a = 25'sd2949120;
         5'd1:    a = 25'sd1740967;
         5'd2:    a = 25'sd919879;
         5'd3:    a = 25'sd466945;
         5'd4:    a = 25'sd234379;
         5'd5:    a = 25'sd117304;
         5'd6:    a = 25'sd58666;
         5'd7:    a = 25'sd29335;
         5'd8:    a = 25'sd14668;
         5'd9:    a = 25'sd7334;
         5'd10:   a = 25'sd3667;
         5'd11:   a = 25'sd1833;
         5'd12:   a = 25'sd917;
         5'd13:   a = 25'sd458;
         5'd14:   a = 25'sd229;
         5'd15:   a = 25'sd115;
         5'd16:   a = 25'sd57;
         5'd17:   a = 25'sd29;
         5'd18:   a = 25'sd14;
         5'd19:   a = 25'sd7;
         5'd20:   a = 25'sd4;
         5'd21:   a = 25'sd2;
         5'd22:   a = 25'sd1;
         default: a = 25'sd0;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/core/eddy_cfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy channel feature extract: sequencer
// Walks one completed group through divide and average, then delta, square, iterate and phase on a measure group.
// ----------------------------------------------------------------------------
module eddy_cfe_ctrl import eddy_cfe_pkg::*; #(
   parameter int ANGLE_ITERATIONS = DEFAULT_ANGLE_ITERATIONS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  cfe_status_type status,
   output cfe_cmd_type    cmd
);

   localparam int ITER_STEPS = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;

   typedef enum logic [3:0] {
      S_IDLE, S_DIVIDE, S_AVERAGE, S_DELTA, S_SQUARE_A, S_SQUARE_B,
      S_ITERATE, S_PHASE, S_OUTPUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_tvalid && status.group_done) state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = S_AVERAGE;
         end
         S_AVERAGE:  state_in = status.is_cal ? S_OUTPUT : S_DELTA;
         S_DELTA:    state_in = S_SQUARE_A;
         S_SQUARE_A: state_in = S_SQUARE_B;
         S_SQUARE_B: begin
            step_in  = '0;
            state_in = S_ITERATE;
         end
         S_ITERATE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ITER_STEPS - 1)) state_in = S_PHASE;
         end
         S_PHASE:  state_in = S_OUTPUT;
         S_OUTPUT: if (status.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.accept   = (state_ff == S_IDLE) && req_tvalid;
      cmd.div_step = (state_ff == S_DIVIDE);
      cmd.average  = (state_ff == S_AVERAGE);
      cmd.delta    = (state_ff == S_DELTA);
      cmd.square_a = (state_ff == S_SQUARE_A);
      cmd.square_b = (state_ff == S_SQUARE_B);
      cmd.iterate  = (state_ff == S_ITERATE);
      cmd.phase    = (state_ff == S_PHASE);
      cmd.load_out = (state_ff == S_OUTPUT) && status.out_free;
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ----- rtl/core/eddy_cfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy channel feature extract: datapath
// Accumulators, divider lanes, baseline memory, square root, CORDIC lanes.
// ----------------------------------------------------------------------------
module eddy_cfe_dp import eddy_cfe_pkg::*; #(
   parameter int CHANNELS         = DEFAULT_CHANNELS,
   parameter int ANGLE_ITERATIONS = DEFAULT_ANGLE_ITERATIONS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfe_cmd_type                cmd,
   output cfe_status_type             status,
   input  logic                       action,
   input  logic [CHAN_W-1:0]          channel,
   input  logic signed [SAMPLE_W-1:0] re_sample,
   input  logic signed [SAMPLE_W-1:0] im_sample,
   input  logic                       csr_write,
   input  logic [COUNT_W-1:0]         csr_data,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [CHAN_W-1:0]          out_channel,
   output logic                       was_calibration,
   output logic [SAMPLE_W-1:0]        re_change,
   output logic [SAMPLE_W-1:0]        im_change,
   output logic [AMP_W-1:0]           amplitude,
   output logic signed [PHASE_W-1:0]  phase_centideg
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W   = 7;
   localparam int REM_D_W = COUNT_W + 1;
   localparam int SQ_W    = 2 * ACC_W;
   localparam int RAD_W   = 2 * SQRT_STEPS;
   localparam int ROOT_W  = SQRT_STEPS;
   localparam int REM_W   = ROOT_W + 3;
   localparam int DIFF_W  = ZW + 1;
   localparam int SCALE_W = DIFF_W + 7;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } lane_type;

   function automatic lane_type lane_init(input logic signed [ACC_W-1:0] re,
                                          input logic signed [ACC_W-1:0] im);
      lane_type             l;
      logic signed [CW-1:0] x0, y0;
      x0 = {{(CW-ACC_W-8){im[ACC_W-1]}}, im, 8'b0};
      y0 = {{(CW-ACC_W-8){re[ACC_W-1]}}, re, 8'b0};
      l.x = x0;
      l.y = y0;
      l.z = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            l.x = y0;
            l.y = -x0;
            l.z = Z_QUARTER;
         end else begin
            l.x = -y0;
            l.y = x0;
            l.z = -Z_QUARTER;
         end
      end
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l, input logic [STEP_W-1:0] i);
      lane_type             r;
      logic signed [CW-1:0] xs, ys, dx, dy;
      logic signed [ZW-1:0] zs, t;
      xs = l.x;
      ys = l.y;
      zs = l.z;
      dx = ys >>> i;
      dy = xs >>> i;
      t  = atan_angle(i);
      r  = l;
      if (ys > 0) begin
         r.x = xs + dx;
         r.y = ys - dy;
         r.z = zs + t;
      end else if (ys < 0) begin
         r.x = xs - dx;
         r.y = ys + dy;
         r.z = zs - t;
      end
      return r;
   endfunction

   // configuration and accumulation
   logic [COUNT_W-1:0]      count_ff, samples_ff, cnt_next, n_eff, n_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_sum, acc_im_sum;
   logic                    group_done, act_ff;
   logic [CHAN_W-1:0]       chan_ff;

   assign acc_re_sum = acc_re_ff + ACC_W'(re_sample);
   assign acc_im_sum = acc_im_ff + ACC_W'(im_sample);
   assign cnt_next   = samples_ff + 1'b1;
   assign n_eff      = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   assign group_done = (cnt_next >= n_eff);

   // divider lanes
   logic [ACC_W-1:0]   dvd_re_ff, dvd_im_ff;
   logic [REM_D_W-1:0] rem_re_ff, rem_im_ff, sh_re, sh_im;
   logic               neg_re_ff, neg_im_ff, ge_re, ge_im;

   assign sh_re = {rem_re_ff[COUNT_W-1:0], dvd_re_ff[ACC_W-1]};
   assign sh_im = {rem_im_ff[COUNT_W-1:0], dvd_im_ff[ACC_W-1]};
   assign ge_re = (sh_re >= {1'b0, n_ff});
   assign ge_im = (sh_im >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_RESET;
         acc_re_ff  <= '0;
         acc_im_ff  <= '0;
         samples_ff <= '0;
      end else begin
         if (csr_write) count_ff <= csr_data;
         if (cmd.accept) begin
            if (group_done) begin
               acc_re_ff  <= '0;
               acc_im_ff  <= '0;
               samples_ff <= '0;
            end else begin
               acc_re_ff  <= acc_re_sum;
               acc_im_ff  <= acc_im_sum;
               samples_ff <= cnt_next;
            end
         end
      end
   end

   logic signed [ACC_W-1:0] avg_re_ff, avg_im_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && group_done) begin
         act_ff    <= action;
         chan_ff   <= channel;
         n_ff      <= n_eff;
         neg_re_ff <= acc_re_sum[ACC_W-1];
         neg_im_ff <= acc_im_sum[ACC_W-1];
         dvd_re_ff <= acc_re_sum[ACC_W-1] ? ACC_W'(-acc_re_sum) : ACC_W'(acc_re_sum);
         dvd_im_ff <= acc_im_sum[ACC_W-1] ? ACC_W'(-acc_im_sum) : ACC_W'(acc_im_sum);
         rem_re_ff <= '0;
         rem_im_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_re_ff <= ge_re ? sh_re - {1'b0, n_ff} : sh_re;
         rem_im_ff <= ge_im ? sh_im - {1'b0, n_ff} : sh_im;
         dvd_re_ff <= {dvd_re_ff[ACC_W-2:0], ge_re};
         dvd_im_ff <= {dvd_im_ff[ACC_W-2:0], ge_im};
      end
      // truncate toward zero: restore the sign on the magnitude quotient
      if (cmd.average) begin
         avg_re_ff <= neg_re_ff ? -$signed(dvd_re_ff) : $signed(dvd_re_ff);
         avg_im_ff <= neg_im_ff ? -$signed(dvd_im_ff) : $signed(dvd_im_ff);
      end
   end

   // baseline store: re in the low half, im in the high half
   logic [2*SAMPLE_W-1:0] base_mem [CHANNELS];
   logic [CHANNELS-1:0]   base_valid_ff;
   logic [2*SAMPLE_W-1:0] base_rd_ff;
   logic                  base_ok_ff, chan_in_range, base_we;
   logic [EXT_W-1:0]      chan_ext;
   logic [IDX_W-1:0]      chan_idx;

   assign chan_ext      = {2'b00, chan_ff};
   assign chan_idx      = chan_ext[IDX_W-1:0];
   assign chan_in_range = (chan_ext < EXT_W'(CHANNELS));
   assign base_we       = cmd.load_out && act_ff && chan_in_range;

   always_ff @(posedge clock) begin
      if (base_we) base_mem[chan_idx] <= {avg_im_ff[SAMPLE_W-1:0], avg_re_ff[SAMPLE_W-1:0]};
      base_rd_ff <= base_mem[chan_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_valid_ff <= '0;
         base_ok_ff    <= 1'b0;
      end else begin
         if (base_we) base_valid_ff[chan_idx] <= 1'b1;
         base_ok_ff <= chan_in_range && base_valid_ff[chan_idx];
      end
   end

   logic signed [SAMPLE_W-1:0] base_re, base_im;
   logic signed [ACC_W:0]      dre_full, dim_full;

   assign base_re  = base_ok_ff ? $signed(base_rd_ff[SAMPLE_W-1:0]) : '0;
   assign base_im  = base_ok_ff ? $signed(base_rd_ff[2*SAMPLE_W-1:SAMPLE_W]) : '0;
   assign dre_full = (ACC_W+1)'(avg_re_ff) - (ACC_W+1)'(base_re);
   assign dim_full = (ACC_W+1)'(avg_im_ff) - (ACC_W+1)'(base_im);

   // magnitude: squares, then a bit-per-cycle square root
   logic [ACC_W-1:0] dre_ff, dim_ff;
   logic [SQ_W-1:0]  prod_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [REM_W-1:0] rem_ff, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff;
   lane_type         lane_a_ff, lane_b_ff;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.delta) begin
         dre_ff    <= dre_full[ACC_W] ? ACC_W'(-dre_full) : ACC_W'(dre_full);
         dim_ff    <= dim_full[ACC_W] ? ACC_W'(-dim_full) : ACC_W'(dim_full);
         lane_a_ff <= lane_init(avg_re_ff, avg_im_ff);
         lane_b_ff <= lane_init(ACC_W'(base_re), ACC_W'(base_im));
      end
      if (cmd.square_a) prod_ff <= dre_ff * dre_ff;
      if (cmd.square_b) begin
         rad_ff  <= RAD_W'(prod_ff) + RAD_W'(dim_ff * dim_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.iterate) begin
         if (cmd.step < STEP_W'(SQRT_STEPS)) begin
            rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         if (cmd.step < STEP_W'(ANGLE_ITERATIONS)) begin
            lane_a_ff <= lane_step(lane_a_ff, cmd.step);
            lane_b_ff <= lane_step(lane_b_ff, cmd.step);
         end
      end
   end

   // phase: angle difference to centidegrees, round half away from zero
   logic signed [DIFF_W-1:0]  zdiff;
   logic [DIFF_W-1:0]         zmag;
   logic [SCALE_W-1:0]        zext, zscaled;
   logic [PHASE_W-1:0]        ph_raw, ph_sat;
   logic signed [PHASE_W-1:0] phase_ff;

   assign zdiff   = DIFF_W'(lane_a_ff.z) - DIFF_W'(lane_b_ff.z);
   assign zmag    = zdiff[DIFF_W-1] ? DIFF_W'(-zdiff) : DIFF_W'(zdiff);
   assign zext    = SCALE_W'(zmag);
   assign zscaled = (zext << 6) + (zext << 5) + (zext << 2) + SCALE_W'(32768);
   assign ph_raw  = zscaled[16 +: PHASE_W];
   assign ph_sat  = (ph_raw > PHASE_LIMIT) ? PHASE_LIMIT : ph_raw;

   always_ff @(posedge clock) begin
      if (cmd.phase) phase_ff <= zdiff[DIFF_W-1] ? -$signed(ph_sat) : $signed(ph_sat);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_channel     <= chan_ff;
         was_calibration <= act_ff;
         if (act_ff) begin
            re_change      <= '0;
            im_change      <= '0;
            amplitude      <= '0;
            phase_centideg <= '0;
         end else begin
            re_change      <= dre_ff[SAMPLE_W-1:0];
            im_change      <= dim_ff[SAMPLE_W-1:0];
            amplitude      <= root_ff[AMP_W-1:0];
            phase_centideg <= phase_ff;
         end
      end
   end

   assign status.group_done = group_done;
   assign status.is_cal     = act_ff;
   assign status.out_free   = !rsp_tvalid || rsp_tready;

endmodule

// ----- rtl/core/eddy_channel_feature_extract.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy channel feature extract: top level
// Averages I/Q sample groups, keeps per-channel zero baselines and reports
// change magnitude and phase against the baseline.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata channel, re, im; tuser action
//  rsp     | out | rsp_tvalid/tready    | tdata channel, re/im change, amp, phase;
//          |     |                      | tuser was_calibration
//  csr     | in  | csr_valid/ready      | csr_data average_count
//
//  A sample that does not close a group is taken without a stall; a closing
//  sample holds req_tready low through divider, sign, delta, two squares,
//  root beside the CORDIC lanes, phase and load on a measure group, through
//  divider, sign and load on a calibration group, longer while rsp stalls.
//  The result register lets the next samples in while rsp waits.
//  Reset (synchronous, high) clears accumulators, baseline valid bits and rsp.
// ----------------------------------------------------------------------------
module eddy_channel_feature_extract import eddy_cfe_pkg::*; #(
   parameter int CHANNELS         = DEFAULT_CHANNELS,
   parameter int ANGLE_ITERATIONS = DEFAULT_ANGLE_ITERATIONS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] channel, [20:5] re_sample, [36:21] im_sample, [39:37] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] out_channel, [20:5] re_change, [36:21] im_change,
   // [53:37] amplitude, [70:54] phase_centideg, [71] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] was_calibration
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data
);

   cfe_cmd_type               cmd;
   cfe_status_type            status;
   logic [CHAN_W-1:0]         out_channel;
   logic                      was_calibration;
   logic [SAMPLE_W-1:0]       re_change, im_change;
   logic [AMP_W-1:0]          amplitude;
   logic signed [PHASE_W-1:0] phase_centideg;

   // the count register takes a write in any cycle
   assign csr_ready = 1'b1;

   eddy_cfe_ctrl #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   eddy_cfe_dp #(
      .CHANNELS         (CHANNELS),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .action          (req_tuser[0]),
      .channel         (req_tdata[4:0]),
      .re_sample       ($signed(req_tdata[20:5])),
      .im_sample       ($signed(req_tdata[36:21])),
      .csr_write       (csr_valid),
      .csr_data        (csr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .out_channel     (out_channel),
      .was_calibration (was_calibration),
      .re_change       (re_change),
      .im_change       (im_change),
      .amplitude       (amplitude),
      .phase_centideg  (phase_centideg)
   );

   // pack the result fields, lowest field first
   assign rsp_tdata = {1'b0, phase_centideg, amplitude, im_change, re_change, out_channel};
   assign rsp_tuser = was_calibration;

endmodule

// ----- rtl/core/eddy_cfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy channel feature extract: port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module eddy_cfe_checker import eddy_cfe_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   // hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // calibration results carry only the channel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_DATA_W-1:CHAN_W] == '0)
      else $error("calibration result with nonzero fields");

   // phase stays within plus or minus 360.00 degrees
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[70:54]) <= 17'sd36000 &&
                     $signed(rsp_tdata[70:54]) >= -17'sd36000)
      else $error("phase out of range");

   // a new result only appears while the input side is busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a group in progress");

endmodule

bind eddy_channel_feature_extract eddy_cfe_checker u_checker (.*);
